// ----- sv/wsts_pkg.sv -----
// Shared types and constants for the weighted sum-tree sampler.
// Depends on nothing; used by the top level.
`default_nettype none

package wsts_pkg;

    // Capacity, fixed field widths and node memory depth of the block.
    localparam int CAPACITY     = 255;
    localparam int SLOT_BITS    = 8;
    localparam int WEIGHT_BITS  = 16;
    localparam int SUM_BITS     = 24;
    localparam int PAYLOAD_BITS = 32;
    localparam int FUNC_BITS    = 2;
    localparam int STATUS_BITS  = 3;
    localparam int NODE_DEPTH   = 256;

    // Operation codes.
    typedef enum logic [FUNC_BITS-1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_SET   = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_PICK  = 2'd3
    } func_t;

    // Result status codes.
    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_OK          = 3'd0,
        STATUS_FULL        = 3'd1,
        STATUS_BAD_SLOT    = 3'd2,
        STATUS_ZERO_WEIGHT = 3'd3,
        STATUS_EMPTY       = 3'd4,
        STATUS_RANDOM_HIGH = 3'd5
    } status_t;

    // One node memory entry: the slot's payload, its own weight and the
    // subtree sums of its two children.
    typedef struct packed {
        logic [PAYLOAD_BITS-1:0] payload;
        logic [WEIGHT_BITS-1:0]  own;
        logic [SUM_BITS-1:0]     left_sum;
        logic [SUM_BITS-1:0]     right_sum;
    } node_t;

    localparam int NODE_BITS = $bits(node_t);

endpackage

`default_nettype wire

// ----- sv/wsts_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none

module wsts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                     clk,
    input  wire logic                                     wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                         wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- sv/weighted_sum_tree_sampler.sv -----
// Top level of the weighted sum-tree sampler.
// Depends on wsts_pkg and wsts_ram.
`default_nettype none

// The sampler keeps up to 255 weighted slots in a heap-ordered sum tree held
// in a node memory, one entry per slot with its payload, its own weight and
// the sums of its two subtrees, plus a free-slot stack memory.
// After reset the block clears all 256 node memory entries, one entry a
// cycle, and holds in_stall high meanwhile. It then works on one word at a
// time. A word that fails its checks goes straight to the finish step. Set,
// clear and add write back one tree level per cycle as the update climbs
// from the slot to the root; an add that reuses a slot first pops it off the
// free stack. A pick goes down one level per cycle to the chosen slot, then
// back up one level per cycle, as the node memory has a single read port.
// The finish step moves the result into the output register; while
// an earlier result still waits there under out_stall, the finish step waits
// as well, and the next word is accepted only after the result has moved.
module weighted_sum_tree_sampler (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [wsts_pkg::FUNC_BITS-1:0]      func,
    input  wire logic [wsts_pkg::SLOT_BITS-1:0]      slot,
    input  wire logic [wsts_pkg::WEIGHT_BITS-1:0]    weight,
    input  wire logic [wsts_pkg::PAYLOAD_BITS-1:0]   payload_in,
    input  wire logic [wsts_pkg::SUM_BITS-1:0]       random_value,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic      [wsts_pkg::SLOT_BITS-1:0]      slot_out,
    output logic      [wsts_pkg::PAYLOAD_BITS-1:0]   payload_out,
    output logic      [wsts_pkg::SUM_BITS-1:0]       total_weight,
    output logic      [wsts_pkg::STATUS_BITS-1:0]    status
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_POP,
        ST_DOWN,
        ST_UP,
        ST_FINISH
    } state_t;

    localparam logic [wsts_pkg::SLOT_BITS-1:0] SLOT_ONE = wsts_pkg::SLOT_BITS'(1);
    localparam logic [wsts_pkg::SLOT_BITS-1:0] SLOT_CAP =
        wsts_pkg::SLOT_BITS'(wsts_pkg::CAPACITY);

    // Control and working registers.
    state_t                                 state_reg, state_next;
    logic [wsts_pkg::SLOT_BITS-1:0]         clr_addr_reg, clr_addr_next;
    wsts_pkg::func_t                        func_reg, func_next;
    logic [wsts_pkg::WEIGHT_BITS-1:0]       own_reg, own_next;
    logic [wsts_pkg::PAYLOAD_BITS-1:0]      payload_reg, payload_next;
    logic [wsts_pkg::SUM_BITS-1:0]          rnd_reg, rnd_next;
    logic [wsts_pkg::SLOT_BITS-1:0]         node_reg, node_next;
    logic                                   first_reg, first_next;
    logic                                   child_lsb_reg, child_lsb_next;
    logic [wsts_pkg::SUM_BITS-1:0]          sum_reg, sum_next;
    logic [wsts_pkg::SUM_BITS-1:0]          total_reg, total_next;
    logic [wsts_pkg::SLOT_BITS-1:0]         free_count_reg, free_count_next;
    logic [wsts_pkg::SLOT_BITS-1:0]         used_size_reg, used_size_next;
    logic [wsts_pkg::SLOT_BITS-1:0]         slot_res_reg, slot_res_next;
    wsts_pkg::status_t                      status_res_reg, status_res_next;
    logic [wsts_pkg::PAYLOAD_BITS-1:0]      pay_hold_reg, pay_hold_next;

    // Output registers.
    logic                                   out_valid_reg, out_valid_next;
    logic [wsts_pkg::SLOT_BITS-1:0]         out_slot_reg, out_slot_next;
    logic [wsts_pkg::PAYLOAD_BITS-1:0]      out_payload_reg, out_payload_next;
    logic [wsts_pkg::SUM_BITS-1:0]          out_total_reg, out_total_next;
    wsts_pkg::status_t                      out_status_reg, out_status_next;

    // Memory ports.
    logic                                   node_we;
    logic [wsts_pkg::SLOT_BITS-1:0]         node_waddr, node_raddr;
    wsts_pkg::node_t                        node_wdata;
    logic [wsts_pkg::NODE_BITS-1:0]         node_rdata;
    wsts_pkg::node_t                        node_rd;

    logic                                   stk_we;
    logic [wsts_pkg::SLOT_BITS-1:0]         stk_raddr;
    logic [wsts_pkg::SLOT_BITS-1:0]         stk_rdata;

    // Datapath helpers.
    wsts_pkg::func_t                        in_func;
    wsts_pkg::status_t                      acc_status;
    wsts_pkg::node_t                        upd_entry;
    logic [wsts_pkg::SUM_BITS-1:0]          upd_sum;
    logic [wsts_pkg::SUM_BITS-1:0]          r_minus;
    logic                                   go_left, go_right, pick_here, climb;
    logic [wsts_pkg::SLOT_BITS-1:0]         child_left, child_right, parent;
    logic [wsts_pkg::SLOT_BITS-1:0]         used_plus1;

    // Node memory: payload, own weight and child subtree sums per slot.
    wsts_ram #(
        .WIDTH (wsts_pkg::NODE_BITS),
        .DEPTH (wsts_pkg::NODE_DEPTH)
    ) u_node_ram (
        .clk     (clk),
        .wr_en   (node_we),
        .wr_addr (node_waddr),
        .wr_data (node_wdata),
        .rd_addr (node_raddr),
        .rd_data (node_rdata)
    );

    // Free-slot stack memory; the read address always points at the top entry.
    wsts_ram #(
        .WIDTH (wsts_pkg::SLOT_BITS),
        .DEPTH (wsts_pkg::NODE_DEPTH)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (stk_we),
        .wr_addr (free_count_reg),
        .wr_data (node_reg),
        .rd_addr (stk_raddr),
        .rd_data (stk_rdata)
    );

    assign node_rd     = wsts_pkg::node_t'(node_rdata);
    assign stk_raddr   = free_count_reg - SLOT_ONE;
    assign in_func     = wsts_pkg::func_t'(func);
    assign used_plus1  = used_size_reg + SLOT_ONE;
    assign child_left  = {node_reg[wsts_pkg::SLOT_BITS-2:0], 1'b0};
    assign child_right = {node_reg[wsts_pkg::SLOT_BITS-2:0], 1'b1};
    assign parent      = {1'b0, node_reg[wsts_pkg::SLOT_BITS-1:1]};

    // Operand checks on the incoming word.
    always_comb
    begin
        acc_status = wsts_pkg::STATUS_OK;
        case (in_func)
            wsts_pkg::FUNC_ADD:
            begin
                if (weight == '0)
                begin
                    acc_status = wsts_pkg::STATUS_ZERO_WEIGHT;
                end
                else if (free_count_reg == '0 && used_size_reg == SLOT_CAP)
                begin
                    acc_status = wsts_pkg::STATUS_FULL;
                end
            end
            wsts_pkg::FUNC_SET, wsts_pkg::FUNC_CLEAR:
            begin
                if (slot == '0 || slot > used_size_reg)
                begin
                    acc_status = wsts_pkg::STATUS_BAD_SLOT;
                end
                else if (in_func == wsts_pkg::FUNC_SET && weight == '0)
                begin
                    acc_status = wsts_pkg::STATUS_ZERO_WEIGHT;
                end
            end
            wsts_pkg::FUNC_PICK:
            begin
                if (total_reg == '0)
                begin
                    acc_status = wsts_pkg::STATUS_EMPTY;
                end
                else if (random_value >= total_reg)
                begin
                    acc_status = wsts_pkg::STATUS_RANDOM_HIGH;
                end
            end
            default:
            begin
                acc_status = wsts_pkg::STATUS_OK;
            end
        endcase
    end

    // Modified entry of the current node and its new subtree sum. The first
    // node of a walk gets a new own weight (zero for a picked slot) and, for
    // an add, its new payload; every ancestor gets the new sum of the child
    // it came from.
    always_comb
    begin
        upd_entry = node_rd;
        if (state_reg == ST_DOWN)
        begin
            upd_entry.own = '0;
        end
        else if (first_reg)
        begin
            upd_entry.own = own_reg;
            if (func_reg == wsts_pkg::FUNC_ADD)
            begin
                upd_entry.payload = payload_reg;
            end
        end
        else if (child_lsb_reg)
        begin
            upd_entry.right_sum = sum_reg;
        end
        else
        begin
            upd_entry.left_sum = sum_reg;
        end
        upd_sum = wsts_pkg::SUM_BITS'(upd_entry.own) + upd_entry.left_sum
                  + upd_entry.right_sum;
    end

    // Descent decision for a pick.
    assign r_minus   = rnd_reg - node_rd.left_sum;
    assign go_left   = rnd_reg < node_rd.left_sum;
    assign go_right  = !go_left && (r_minus < node_rd.right_sum);
    assign pick_here = (state_reg == ST_DOWN) && !go_left && !go_right;
    assign climb     = (state_reg == ST_UP) || pick_here;

    // Next-state and datapath control.
    always_comb
    begin
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        func_next        = func_reg;
        own_next         = own_reg;
        payload_next     = payload_reg;
        rnd_next         = rnd_reg;
        node_next        = node_reg;
        first_next       = first_reg;
        child_lsb_next   = child_lsb_reg;
        sum_next         = sum_reg;
        total_next       = total_reg;
        free_count_next  = free_count_reg;
        used_size_next   = used_size_reg;
        slot_res_next    = slot_res_reg;
        status_res_next  = status_res_reg;
        pay_hold_next    = pay_hold_reg;
        out_valid_next   = out_valid_reg;
        out_slot_next    = out_slot_reg;
        out_payload_next = out_payload_reg;
        out_total_next   = out_total_reg;
        out_status_next  = out_status_reg;

        node_we    = 1'b0;
        node_waddr = node_reg;
        node_wdata = upd_entry;
        node_raddr = node_reg;
        stk_we     = 1'b0;

        // The output word leaves when the far side takes it.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                node_we       = 1'b1;
                node_waddr    = clr_addr_reg;
                node_wdata    = '0;
                clr_addr_next = clr_addr_reg + SLOT_ONE;
                if (clr_addr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    func_next       = in_func;
                    own_next        = (in_func == wsts_pkg::FUNC_CLEAR) ? '0 : weight;
                    payload_next    = payload_in;
                    rnd_next        = random_value;
                    status_res_next = acc_status;
                    slot_res_next   = '0;
                    pay_hold_next   = '0;
                    first_next      = 1'b1;
                    if (acc_status != wsts_pkg::STATUS_OK)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        case (in_func)
                            wsts_pkg::FUNC_ADD:
                            begin
                                if (free_count_reg != '0)
                                begin
                                    free_count_next = free_count_reg - SLOT_ONE;
                                    state_next      = ST_POP;
                                end
                                else
                                begin
                                    used_size_next = used_plus1;
                                    node_raddr     = used_plus1;
                                    node_next      = used_plus1;
                                    slot_res_next  = used_plus1;
                                    state_next     = ST_UP;
                                end
                            end
                            wsts_pkg::FUNC_SET, wsts_pkg::FUNC_CLEAR:
                            begin
                                node_raddr = slot;
                                node_next  = slot;
                                state_next = ST_UP;
                            end
                            wsts_pkg::FUNC_PICK:
                            begin
                                node_raddr = SLOT_ONE;
                                node_next  = SLOT_ONE;
                                state_next = ST_DOWN;
                            end
                            default:
                            begin
                                state_next = ST_FINISH;
                            end
                        endcase
                    end
                end
            end
            ST_POP:
            begin
                // The reused slot comes off the top of the free stack.
                node_raddr    = stk_rdata;
                node_next     = stk_rdata;
                slot_res_next = stk_rdata;
                state_next    = ST_UP;
            end
            ST_DOWN:
            begin
                if (go_left)
                begin
                    node_raddr = child_left;
                    node_next  = child_left;
                end
                else if (go_right)
                begin
                    rnd_next   = r_minus;
                    node_raddr = child_right;
                    node_next  = child_right;
                end
                else
                begin
                    // This slot is chosen: free it and keep its payload.
                    if (free_count_reg != SLOT_CAP)
                    begin
                        stk_we          = 1'b1;
                        free_count_next = free_count_reg + SLOT_ONE;
                    end
                    pay_hold_next = node_rd.payload;
                    slot_res_next = node_reg;
                end
            end
            ST_UP:
            begin
                state_next = ST_UP;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    out_slot_next    = slot_res_reg;
                    out_payload_next = pay_hold_reg;
                    out_total_next   = total_reg;
                    out_status_next  = status_res_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Write back the current node and move to its parent, or finish at the root.
        if (climb)
        begin
            node_we    = 1'b1;
            node_waddr = node_reg;
            node_wdata = upd_entry;
            if (node_reg == SLOT_ONE)
            begin
                total_next = upd_sum;
                state_next = ST_FINISH;
            end
            else
            begin
                node_raddr     = parent;
                node_next      = parent;
                sum_next       = upd_sum;
                child_lsb_next = node_reg[0];
                first_next     = 1'b0;
                state_next     = ST_UP;
            end
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_addr_reg    <= '0;
            func_reg        <= wsts_pkg::FUNC_ADD;
            own_reg         <= '0;
            payload_reg     <= '0;
            rnd_reg         <= '0;
            node_reg        <= '0;
            first_reg       <= 1'b0;
            child_lsb_reg   <= 1'b0;
            sum_reg         <= '0;
            total_reg       <= '0;
            free_count_reg  <= '0;
            used_size_reg   <= '0;
            slot_res_reg    <= '0;
            status_res_reg  <= wsts_pkg::STATUS_OK;
            pay_hold_reg    <= '0;
            out_valid_reg   <= 1'b0;
            out_slot_reg    <= '0;
            out_payload_reg <= '0;
            out_total_reg   <= '0;
            out_status_reg  <= wsts_pkg::STATUS_OK;
        end
        else
        begin
            state_reg       <= state_next;
            clr_addr_reg    <= clr_addr_next;
            func_reg        <= func_next;
            own_reg         <= own_next;
            payload_reg     <= payload_next;
            rnd_reg         <= rnd_next;
            node_reg        <= node_next;
            first_reg       <= first_next;
            child_lsb_reg   <= child_lsb_next;
            sum_reg         <= sum_next;
            total_reg       <= total_next;
            free_count_reg  <= free_count_next;
            used_size_reg   <= used_size_next;
            slot_res_reg    <= slot_res_next;
            status_res_reg  <= status_res_next;
            pay_hold_reg    <= pay_hold_next;
            out_valid_reg   <= out_valid_next;
            out_slot_reg    <= out_slot_next;
            out_payload_reg <= out_payload_next;
            out_total_reg   <= out_total_next;
            out_status_reg  <= out_status_next;
        end
    end

    // Port drive.
    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign slot_out     = out_slot_reg;
    assign payload_out  = out_payload_reg;
    assign total_weight = out_total_reg;
    assign status       = out_status_reg;

`ifndef SYNTHESIS
    // A slot chosen by the descent must carry weight of its own.
    a_pick_has_weight: assert property (@(posedge clk) disable iff (!rst_n)
        pick_here |-> (node_rd.own != '0))
        else $error("picked slot has zero own weight");

    // The descent never steps below the last slot of the tree.
    a_down_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DOWN) && (go_left || go_right))
            |-> !node_reg[wsts_pkg::SLOT_BITS-1])
        else $error("descent left the slot range");

    // The climb never reaches the unused node zero.
    a_up_node_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UP) |-> (node_reg != '0))
        else $error("update walk reached node zero");

    // A new output word only comes out of the finish step.
    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("output word raised outside finish");
`endif

endmodule

`default_nettype wire
